// ----- rtl/aapr_pkg.sv -----
// Shared types and constants for the axis-angle point rotation pipeline.
// Used by aapr_horner_cell and axis_angle_point_rotation_top.
package aapr_pkg;

  localparam int unsigned NCELL = 7;
  localparam int unsigned NSIN  = 6;
  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;

  // Horner state handed along the cell chain
  typedef struct packed {
    logic [30:0] r;
    logic [31:0] r2;
    logic [30:0] ts;
    logic [30:0] tc;
  } aapr_trig_t;

  // item fields riding alongside the trig work
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [17:0] ax;
    logic signed [17:0] ay;
    logic signed [17:0] az;
    logic [1:0]         quad;
  } aapr_pay_t;

  function automatic int unsigned sin_div(int unsigned i);
    case (i)
      0: sin_div = 156;
      1: sin_div = 110;
      2: sin_div = 72;
      3: sin_div = 42;
      4: sin_div = 20;
      default: sin_div = 6;
    endcase
  endfunction

  function automatic int unsigned cos_div(int unsigned i);
    case (i)
      0: cos_div = 182;
      1: cos_div = 132;
      2: cos_div = 90;
      3: cos_div = 56;
      4: cos_div = 30;
      5: cos_div = 12;
      default: cos_div = 2;
    endcase
  endfunction

endpackage

// ----- rtl/axis_angle_point_rotation_top.sv -----
// Axis-angle point rotation: stream in, stream out, fully pipelined.
// Depends on aapr_pkg and aapr_horner_cell.
//
// Usage:
//   in_*  : one request per point; tdata carries point, axis and angle.
//   out_* : one rotated point per request, in order.
//   Throughput is one request per cycle while in_tready is high. From the
//   accepting edge to out_tvalid a request passes three stages for the
//   angle to radians and its square, a chain of seven Horner cells of three
//   stages each, two trig finishing stages, two matrix stages, two output
//   stages and the output register.
//   A stalled receiver is absorbed by a spare register behind the output
//   register; only once both are full does in_tready fall and the whole
//   pipeline hold. No request is dropped or repeated.
//   Reset (rst_n low, synchronous) empties the pipeline and the output
//   registers; no state survives between requests.
//   The axis is used as given, without normalisation; outputs saturate to
//   the signed Q16.16 range.
module axis_angle_point_rotation_top import aapr_pkg::*; #(
  parameter int unsigned TRIG_FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // point_x[31:0], point_y[63:32], point_z[95:64], axis_x[113:96],
  // axis_y[131:114], axis_z[149:132], turn_angle[165:150], zero pad
  input  logic [167:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // rotated_x[31:0], rotated_y[63:32], rotated_z[95:64]
  output logic [95:0]  out_tdata
);

  localparam int F  = TRIG_FRAC_BITS;
  localparam int TW = F + 2;        // signed sin/cos
  localparam int OW = F + 3;        // signed 1 - cos
  localparam int EW = F + 40;       // matrix entry before rounding
  localparam int MW = F + 8;        // matrix entry in Q(F)
  localparam int PW = 32 + MW;      // point times entry
  localparam int AW = PW + 2;       // sum of three
  localparam logic signed [TW-1:0] ONE_T = TW'(1) <<< F;
  localparam logic signed [AW-1:0] SAT_HI = AW'(33'sh0_7FFF_FFFF);
  localparam logic signed [AW-1:0] SAT_LO = -(AW'(33'sh0_7FFF_FFFF)) - AW'(1);

  logic en;
  logic accept;

  // radians front end
  logic        v1_r, v2_r, v3_r;
  aapr_pay_t   p1_r, p2_r, p3_r;
  logic [46:0] rprod_r;
  logic [30:0] r2s_r;
  aapr_trig_t  trig3_r;
  logic [61:0] rsq;
  logic [46:0] rround;

  assign accept = in_tvalid & in_tready;
  assign rround = rprod_r + 47'h8000;
  assign rsq    = {31'd0, r2s_r} * {31'd0, r2s_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r.px   <= in_tdata[31:0];
      p1_r.py   <= in_tdata[63:32];
      p1_r.pz   <= in_tdata[95:64];
      p1_r.ax   <= in_tdata[113:96];
      p1_r.ay   <= in_tdata[131:114];
      p1_r.az   <= in_tdata[149:132];
      p1_r.quad <= in_tdata[165:164];
      rprod_r   <= {33'd0, in_tdata[163:150]} * {14'd0, TWO_PI_Q30};
      p2_r      <= p1_r;
      r2s_r     <= rround[46:16];
      p3_r      <= p2_r;
      trig3_r.r  <= r2s_r;
      trig3_r.r2 <= rsq[61:30];
      trig3_r.ts <= Q30_ONE;
      trig3_r.tc <= Q30_ONE;
    end
  end

  // Horner chain
  logic       cv   [NCELL+1];
  aapr_trig_t ct   [NCELL+1];
  aapr_pay_t  cp   [NCELL+1];

  assign cv[0] = v3_r;
  assign ct[0] = trig3_r;
  assign cp[0] = p3_r;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    aapr_horner_cell #(
      .SIN_D  (sin_div(i)),
      .COS_D  (cos_div(i)),
      .SIN_ON (i < NSIN)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (cv[i]),
      .in_trig   (ct[i]),
      .in_pay    (cp[i]),
      .out_valid (cv[i+1]),
      .out_trig  (ct[i+1]),
      .out_pay   (cp[i+1])
    );
  end

  // trig finish
  logic        vt1_r, vt2_r;
  aapr_pay_t   pt1_r, pt2_r;
  logic [30:0] sraw_r, craw_r;
  logic signed [TW-1:0] sn_r, cs_r;
  logic [61:0] sprod;
  logic [31:0] sr, cr;
  logic [TW-1:0] so, co;
  logic [F:0]  sq, cq;
  logic signed [TW-1:0] sx, cx, sn_nxt, cs_nxt;

  assign sprod = {31'd0, ct[NCELL].r} * {31'd0, ct[NCELL].ts};

  always_comb begin
    sr = {1'b0, sraw_r} + (32'd1 << (29 - F));
    cr = {1'b0, craw_r} + (32'd1 << (29 - F));
    so = TW'(sr >> (30 - F));
    co = TW'(cr >> (30 - F));
    sq = (so > TW'(ONE_T)) ? ONE_T[F:0] : so[F:0];
    cq = (co > TW'(ONE_T)) ? ONE_T[F:0] : co[F:0];
    sx = $signed({1'b0, sq});
    cx = $signed({1'b0, cq});
    case (pt1_r.quad)
      2'd0: begin sn_nxt = sx;  cs_nxt = cx;  end
      2'd1: begin sn_nxt = cx;  cs_nxt = -sx; end
      2'd2: begin sn_nxt = -sx; cs_nxt = -cx; end
      default: begin sn_nxt = -cx; cs_nxt = sx; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt1_r <= 1'b0;
      vt2_r <= 1'b0;
    end else if (en) begin
      vt1_r <= cv[NCELL];
      vt2_r <= vt1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sraw_r <= sprod[60:30];
      craw_r <= ct[NCELL].tc;
      pt1_r  <= cp[NCELL];
      sn_r   <= sn_nxt;
      cs_r   <= cs_nxt;
      pt2_r  <= pt1_r;
    end
  end

  // matrix
  logic vm1_r, vm2_r;
  logic signed [31:0] pm1_r [3];
  logic signed [31:0] pm2_r [3];
  logic signed [35:0] aa_r  [3][3];
  logic signed [TW+17:0] ask_r [3];
  logic signed [OW-1:0] omc_r;
  logic signed [TW-1:0] csm_r;
  logic signed [MW-1:0] m_r [3][3];
  logic signed [17:0] ax [3];
  logic signed [31:0] px [3];
  logic signed [EW-1:0] e [3][3];

  assign ax[0] = pt2_r.ax;
  assign ax[1] = pt2_r.ay;
  assign ax[2] = pt2_r.az;
  assign px[0] = pt2_r.px;
  assign px[1] = pt2_r.py;
  assign px[2] = pt2_r.pz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        e[i][j] = EW'(aa_r[i][j]) * EW'(omc_r);
        if (i == j) begin
          e[i][j] = e[i][j] + (EW'(csm_r) <<< 32);
        end else if ((i + 1) % 3 == j) begin
          e[i][j] = e[i][j] - (EW'(ask_r[3 - i - j]) <<< 16);
        end else begin
          e[i][j] = e[i][j] + (EW'(ask_r[3 - i - j]) <<< 16);
        end
        e[i][j] = (e[i][j] + (EW'(1) <<< 31)) >>> 32;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm1_r <= 1'b0;
      vm2_r <= 1'b0;
    end else if (en) begin
      vm1_r <= vt2_r;
      vm2_r <= vm1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      omc_r <= OW'(ONE_T) - OW'(cs_r);
      csm_r <= cs_r;
      for (int i = 0; i < 3; i++) begin
        pm1_r[i] <= px[i];
        pm2_r[i] <= pm1_r[i];
        ask_r[i] <= ax[i] * sn_r;
        for (int j = 0; j < 3; j++) begin
          aa_r[i][j] <= ax[i] * ax[j];
          m_r[i][j]  <= MW'(e[i][j]);
        end
      end
    end
  end

  // output products and sums
  logic vo1_r, vo2_r;
  logic signed [PW-1:0] pr_r [3][3];
  logic signed [31:0]   res_r [3];
  logic signed [AW-1:0] acc [3];
  logic signed [31:0]   res_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = AW'(pr_r[i][0]) + AW'(pr_r[i][1]) + AW'(pr_r[i][2]);
      acc[i] = (acc[i] + (AW'(1) <<< (F - 1))) >>> F;
      if (acc[i] > SAT_HI) begin
        res_nxt[i] = 32'sh7FFF_FFFF;
      end else if (acc[i] < SAT_LO) begin
        res_nxt[i] = 32'sh8000_0000;
      end else begin
        res_nxt[i] = acc[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo1_r <= 1'b0;
      vo2_r <= 1'b0;
    end else if (en) begin
      vo1_r <= vm2_r;
      vo2_r <= vo1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr_r[i][j] <= PW'(pm2_r[j]) * PW'(m_r[i][j]);
        end
        res_r[i] <= res_nxt[i];
      end
    end
  end

  // output register with spare slot
  logic        out_v_r, spare_v_r;
  logic [95:0] out_d_r, spare_d_r;
  logic [95:0] pipe_d;

  assign pipe_d    = {res_r[2], res_r[1], res_r[0]};
  assign en        = !spare_v_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r   <= 1'b0;
      spare_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (spare_v_r) begin
        out_v_r   <= 1'b1;
        spare_v_r <= 1'b0;
      end else begin
        out_v_r <= vo2_r;
      end
    end else if (vo2_r && !spare_v_r) begin
      spare_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      out_d_r <= spare_v_r ? spare_d_r : pipe_d;
    end else if (!spare_v_r) begin
      spare_d_r <= pipe_d;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule

// ----- rtl/aapr_horner_cell.sv -----
// One Horner step t <- max(0, 1 - (r2*t >> 30) / d): cosine lane, sine lane if SIN_ON.
// Three register stages; division by d is a reciprocal multiply plus one correction.
// Depends on aapr_pkg.
module aapr_horner_cell import aapr_pkg::*; #(
  parameter int unsigned SIN_D  = 156,
  parameter int unsigned COS_D  = 182,
  parameter bit          SIN_ON = 1'b1
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_valid,
  input  aapr_trig_t in_trig,
  input  aapr_pay_t  in_pay,
  output logic       out_valid,
  output aapr_trig_t out_trig,
  output aapr_pay_t  out_pay
);

  localparam logic [31:0] MS = 32'((64'd1 << 32) / SIN_D);
  localparam logic [31:0] MC = 32'((64'd1 << 32) / COS_D);
  localparam logic [32:0] DS = 33'(SIN_D);
  localparam logic [32:0] DC = 33'(COS_D);

  logic       va_r, vb_r, vc_r;
  aapr_trig_t ta_r, tb_r, tc_r;
  aapr_pay_t  pa_r, pb_r, pc_r;
  logic [31:0] xs_a_r, xc_a_r, xs_b_r, xc_b_r;
  logic [31:0] qs_b_r, qc_b_r;

  logic [63:0] prod_s, prod_c, est_s, est_c;
  logic [32:0] rem_s, rem_c;
  logic [32:0] qs, qc;
  logic signed [33:0] vs, vc;
  aapr_trig_t  t_nxt;

  always_comb begin
    prod_s = {32'd0, in_trig.r2} * {33'd0, in_trig.ts};
    prod_c = {32'd0, in_trig.r2} * {33'd0, in_trig.tc};
    est_s  = {32'd0, xs_a_r} * {32'd0, MS};
    est_c  = {32'd0, xc_a_r} * {32'd0, MC};
    rem_s  = {1'b0, xs_b_r} - 33'({1'b0, qs_b_r} * DS);
    rem_c  = {1'b0, xc_b_r} - 33'({1'b0, qc_b_r} * DC);
    qs     = {1'b0, qs_b_r} + ((rem_s >= DS) ? 33'd1 : 33'd0);
    qc     = {1'b0, qc_b_r} + ((rem_c >= DC) ? 33'd1 : 33'd0);
    vs     = $signed({3'b0, Q30_ONE}) - $signed({1'b0, qs});
    vc     = $signed({3'b0, Q30_ONE}) - $signed({1'b0, qc});
    t_nxt  = tb_r;
    if (SIN_ON) begin
      t_nxt.ts = (vs < 0) ? 31'd0 : vs[30:0];
    end
    t_nxt.tc = (vc < 0) ? 31'd0 : vc[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ta_r   <= in_trig;
      pa_r   <= in_pay;
      xs_a_r <= prod_s[61:30];
      xc_a_r <= prod_c[61:30];
      tb_r   <= ta_r;
      pb_r   <= pa_r;
      xs_b_r <= xs_a_r;
      xc_b_r <= xc_a_r;
      qs_b_r <= est_s[63:32];
      qc_b_r <= est_c[63:32];
      tc_r   <= t_nxt;
      pc_r   <= pb_r;
    end
  end

  assign out_valid = vc_r;
  assign out_trig  = tc_r;
  assign out_pay   = pc_r;

endmodule
